// ===== rtl/mteu_pkg.sv =====
// Shared types and constants of the multi-turn encoder unwrapper.
package mteu_pkg;

   localparam int CHANNELS_DEF  = 2;
   localparam int TURN_BITS_DEF = 16;

   localparam int RAW_W       = 16;
   localparam int SAMPLE_W    = 12;
   localparam int ANGLE_W     = 35;
   localparam int TURNS_W     = 16;
   localparam int MAG_W       = 29;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 12;

   localparam logic [CSR_IDX_W-1:0] CSR_GLITCH_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GLITCH_HIGH = 2'd1;

   localparam logic [SAMPLE_W-1:0] GLITCH_LOW_RST  = 12'd300;
   localparam logic [SAMPLE_W-1:0] GLITCH_HIGH_RST = 12'd3796;

   localparam logic signed [SAMPLE_W:0] WRAP_STEP     = 13'sd2048;
   localparam logic signed [SAMPLE_W:0] WRAP_STEP_NEG = -13'sd2048;

   // 2*pi in unsigned Q32, split into a low word and the bits above it.
   localparam logic [31:0] TWO_PI_LO = 32'h487E_D511;
   localparam logic [2:0]  TWO_PI_HI = 3'd6;

   localparam logic [MAG_W-1:0] MAG_CLAMP  = 29'h1000_0000;
   localparam logic [63:0]      ROUND_BIAS = 64'h0000_0000_0800_0000;

   localparam logic [35:0] ANGLE_POS_LIM = 36'h3_FFFF_FFFF;
   localparam logic [35:0] ANGLE_NEG_LIM = 36'h4_0000_0000;
   localparam logic [ANGLE_W-1:0] ANGLE_MAX = 35'h3_FFFF_FFFF;
   localparam logic [ANGLE_W-1:0] ANGLE_MIN = 35'h4_0000_0000;

   typedef struct packed {
      logic                channel;
      logic [RAW_W-1:0]    raw_word;
      logic                read_ok;
   } sample_type;

   typedef struct packed {
      logic [MAG_W-1:0]         mag;
      logic                     neg;
      logic signed [TURNS_W-1:0] turns;
      logic                     held;
   } conv_req_type;

endpackage

// ===== rtl/mteu_if.sv =====
// Channel interfaces of the multi-turn encoder unwrapper.
interface mteu_req_if import mteu_pkg::*; ();
   logic             valid;
   logic             ready;
   logic             channel;
   logic [RAW_W-1:0] raw_word;
   logic             read_ok;

   modport source (output valid, channel, raw_word, read_ok, input ready);
   modport sink (input valid, channel, raw_word, read_ok, output ready);
endinterface

interface mteu_rsp_if import mteu_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic signed [ANGLE_W-1:0] angle_q16;
   logic signed [TURNS_W-1:0] turns;
   logic                      held;

   modport source (output valid, angle_q16, turns, held, input ready);
   modport sink (input valid, angle_q16, turns, held, output ready);
endinterface

interface mteu_csr_if import mteu_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/mteu_angle.sv =====
// Two-stage conversion of a clamped turn-and-sample count to a Q16 radian angle.
module mteu_angle import mteu_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  conv_req_type  in_item,
   mteu_rsp_if.source    rsp
);

   typedef struct packed {
      logic [60:0]               p_lo;
      logic [31:0]               p_hi;
      logic                      neg;
      logic signed [TURNS_W-1:0] turns;
      logic                      held;
   } prod_type;

   typedef struct packed {
      logic signed [ANGLE_W-1:0] angle;
      logic signed [TURNS_W-1:0] turns;
      logic                      held;
   } result_type;

   logic       va_ff, va_in;
   logic       vo_ff, vo_in;
   prod_type   a_ff, a_in;
   result_type o_ff, o_in;
   logic       out_free;
   logic [63:0] total;
   logic [35:0] r;

   assign out_free = !vo_ff || rsp.ready;
   assign in_ready = !va_ff || out_free;

   always_comb begin
      a_in.p_lo  = 61'(in_item.mag) * 61'(TWO_PI_LO);
      a_in.p_hi  = 32'(in_item.mag) * 32'(TWO_PI_HI);
      a_in.neg   = in_item.neg;
      a_in.turns = in_item.turns;
      a_in.held  = in_item.held;
   end

   always_comb begin
      total = {a_ff.p_hi, 32'd0} + {3'd0, a_ff.p_lo} + ROUND_BIAS;
      r     = total[63:28];
      if (a_ff.neg) begin
         if (r > ANGLE_NEG_LIM) begin
            o_in.angle = ANGLE_MIN;
         end else begin
            o_in.angle = ANGLE_W'(36'd0 - r);
         end
      end else begin
         if (r > ANGLE_POS_LIM) begin
            o_in.angle = ANGLE_MAX;
         end else begin
            o_in.angle = ANGLE_W'(r);
         end
      end
      o_in.turns = a_ff.turns;
      o_in.held  = a_ff.held;
   end

   assign va_in = in_ready ? in_valid : va_ff;
   assign vo_in = out_free ? va_ff : vo_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         va_ff <= va_in;
         vo_ff <= vo_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         a_ff <= a_in;
      end
      if (out_free && va_ff) begin
         o_ff <= o_in;
      end
   end

   assign rsp.valid     = vo_ff;
   assign rsp.angle_q16 = o_ff.angle;
   assign rsp.turns     = o_ff.turns;
   assign rsp.held      = o_ff.held;

endmodule

// ===== rtl/multiturn_encoder_unwrap.sv =====
// Multi-turn unwrapper for 12-bit absolute encoder samples, top level.
//
// Samples arrive on the req_bus channel, one transfer per sample, carrying the
// channel number, the raw 16-bit angle register word and the bus acknowledge
// flag. Each sample yields exactly one transfer on rsp_bus with the multi-turn
// angle in Q16 radians, the channel's turn count and a flag that is set when
// the sample was rejected and the previous angle repeated.
// The user must write the glitch thresholds through csr_bus only while no sample
// is in flight; the block does not enforce this, and csr_bus is always ready.
// A result passes through an input register, the per-channel state update, the
// product stage of the constant multiply and the result register. A sample can
// be taken in every cycle while rsp_bus is ready, so the sustained rate is one
// sample per cycle; the per-channel state is read and written in the same cycle,
// which lets back-to-back samples of one channel follow each other.
// Reset clears the pipeline, sets every channel to await its first good sample
// and restores both thresholds to their default values.
// When the receiver stalls, the stages fill one by one; up to four samples are
// held before req_bus drops ready.
module multiturn_encoder_unwrap import mteu_pkg::*; #(
   parameter int CHANNELS  = CHANNELS_DEF,
   parameter int TURN_BITS = TURN_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   mteu_req_if.sink   req_bus,
   mteu_rsp_if.source rsp_bus,
   mteu_csr_if.sink   csr_bus
);

   localparam int USED = (CHANNELS < 2) ? CHANNELS : 2;
   localparam int CW   = TURN_BITS + SAMPLE_W;
   localparam logic signed [TURN_BITS-1:0] TC_MAX = {1'b0, {(TURN_BITS-1){1'b1}}};
   localparam logic signed [TURN_BITS-1:0] TC_MIN = {1'b1, {(TURN_BITS-1){1'b0}}};

   logic [SAMPLE_W-1:0]        glitch_low_ff, glitch_high_ff;
   logic [SAMPLE_W-1:0]        prev_ff  [USED];
   logic signed [TURN_BITS-1:0] tc_ff   [USED];
   logic                       first_ff [USED];

   logic         v0_ff, v1_ff;
   sample_type   s0_ff;
   conv_req_type s1_ff, s1_in;
   logic         conv_ready;
   logic         s1_free, s0_go;

   logic                        ch_ok, idx, good, glitch, upd, zero;
   logic [SAMPLE_W-1:0]         sample, prev, mag, raw_sel;
   logic signed [SAMPLE_W:0]    step;
   logic signed [TURN_BITS-1:0] tc, tc_next, tc_sel;
   logic                        first;
   logic signed [CW-1:0]        count;
   logic [CW-1:0]               cmag;
   logic [MAG_W-1:0]            m;
   logic signed [TURN_BITS+15:0] tc_ext;

   assign csr_bus.ready = 1'b1;

   assign s1_free       = !v1_ff || conv_ready;
   assign s0_go         = v0_ff && s1_free;
   assign req_bus.ready = !v0_ff || s1_free;

   always_comb begin
      ch_ok  = (CHANNELS > 1) || (s0_ff.channel == 1'b0);
      idx    = s0_ff.channel & ch_ok;
      sample = s0_ff.raw_word[SAMPLE_W-1:0];
      good   = s0_ff.read_ok && (s0_ff.raw_word[RAW_W-1:SAMPLE_W] == 4'd0) && ch_ok;
      prev   = prev_ff[idx];
      tc     = tc_ff[idx];
      first  = first_ff[idx];
      step   = $signed({1'b0, sample}) - $signed({1'b0, prev});
      mag    = (step < 0) ? SAMPLE_W'(-step) : SAMPLE_W'(step);
      glitch = !first && (mag > glitch_low_ff) && (mag < glitch_high_ff);
      upd    = good && !glitch;

      tc_next = tc;
      if (!first) begin
         if (step > WRAP_STEP) begin
            if (tc != TC_MIN) begin
               tc_next = tc - 1'b1;
            end
         end else if (step < WRAP_STEP_NEG) begin
            if (tc != TC_MAX) begin
               tc_next = tc + 1'b1;
            end
         end
      end

      tc_sel  = upd ? tc_next : tc;
      raw_sel = upd ? sample : prev;
      count   = {tc_sel, raw_sel};
      cmag    = count[CW-1] ? CW'(-count) : CW'(count);
      m       = (64'(cmag) > 64'(MAG_CLAMP)) ? MAG_CLAMP : MAG_W'(cmag);
      zero    = !ch_ok || (!upd && first);
      tc_ext  = {{16{tc_sel[TURN_BITS-1]}}, tc_sel};

      s1_in.mag   = zero ? '0 : m;
      s1_in.neg   = zero ? 1'b0 : count[CW-1];
      s1_in.turns = zero ? '0 : tc_ext[TURNS_W-1:0];
      s1_in.held  = !upd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff          <= 1'b0;
         v1_ff          <= 1'b0;
         glitch_low_ff  <= GLITCH_LOW_RST;
         glitch_high_ff <= GLITCH_HIGH_RST;
         for (int c = 0; c < USED; c++) begin
            prev_ff[c]  <= '0;
            tc_ff[c]    <= '0;
            first_ff[c] <= 1'b1;
         end
      end else begin
         if (req_bus.ready) begin
            v0_ff <= req_bus.valid;
         end
         if (s1_free) begin
            v1_ff <= v0_ff;
         end
         if (s0_go && upd) begin
            prev_ff[idx]  <= sample;
            tc_ff[idx]    <= tc_next;
            first_ff[idx] <= 1'b0;
         end
         if (csr_bus.valid) begin
            unique case (csr_bus.index)
               CSR_GLITCH_LOW:  glitch_low_ff  <= csr_bus.data;
               CSR_GLITCH_HIGH: glitch_high_ff <= csr_bus.data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_bus.ready) begin
         s0_ff.channel  <= req_bus.channel;
         s0_ff.raw_word <= req_bus.raw_word;
         s0_ff.read_ok  <= req_bus.read_ok;
      end
      if (s0_go) begin
         s1_ff <= s1_in;
      end
   end

   mteu_angle u_angle (
      .clock    (clock),
      .reset    (reset),
      .in_valid (v1_ff),
      .in_ready (conv_ready),
      .in_item  (s1_ff),
      .rsp      (rsp_bus)
   );

   // A rejected sample of channel 0 must leave that channel's turn count and previous sample untouched.
   assert property (@(posedge clock) disable iff (reset)
      s0_go && (idx == 1'b0) && !upd |=> $stable(tc_ff[0]) && $stable(prev_ff[0]))
      else $error("rejected sample changed channel state");

   // The turn count of channel 0 moves by at most one turn per cycle.
   assert property (@(posedge clock) disable iff (reset)
      (tc_ff[0] == $past(tc_ff[0])) || (tc_ff[0] == $past(tc_ff[0]) + 1'b1) ||
      (tc_ff[0] == $past(tc_ff[0]) - 1'b1))
      else $error("turn count jumped by more than one");

   // Once channel 0 has its reference it never awaits a first sample again until reset.
   assert property (@(posedge clock) disable iff (reset)
      !first_ff[0] |=> !first_ff[0])
      else $error("first-sample flag set again without reset");

endmodule
